### design/scale_mask_pitch_quantizer_macros.svh
// ----------------------------------------------------------------------------
// Scale-mask pitch quantizer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCALE_MASK_PITCH_QUANTIZER_MACROS_SVH
`define SCALE_MASK_PITCH_QUANTIZER_MACROS_SVH

// same-cycle implication
`define SMPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/smpq_pkg.sv
// ----------------------------------------------------------------------------
// Scale-mask pitch quantizer package
// Widths, register codes, word types, search tables and modulo-12 helpers.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int PITCH_W   = 18;
    localparam int NOTE_W    = 12;
    localparam int MASK_W    = 12;
    localparam int ROOT_W    = 4;
    localparam int HYST_W    = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W     = 4;
    localparam int CENTS_W   = 19;
    localparam int OFF_W     = 5;
    localparam int CAND      = 25;
    localparam int SPAN      = 12;
    localparam int OCTAVE    = 12;
    localparam int CENTS_PER = 100;
    localparam int REM_W     = 7;
    localparam int Q_W       = 12;

    // floor((p + 50) / 100) computed as floor((p + PITCH_BIAS) / 100) - NEAR_BIAS
    localparam int NEAR_BIAS     = 1312;
    localparam int PITCH_BIAS    = 50 + NEAR_BIAS * CENTS_PER;
    localparam int NEAR_MOD_BIAS = NEAR_BIAS % OCTAVE;
    localparam int BIASED_W      = 19;
    localparam int RECIP_100     = 671089;
    localparam int RECIP_100_SH  = 26;
    localparam int RECIP_100_W   = 20;
    localparam int RECIP_12      = 5462;
    localparam int RECIP_12_SH   = 16;
    localparam int RECIP_12_W    = 13;
    localparam int HALF_NEG      = -50;

    localparam int QUEUE_DEPTH_DEFAULT = 8;

    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;
    localparam logic [ROOT_W-1:0] ROOT_RESET = 4'd0;
    localparam logic [HYST_W-1:0] HYST_RESET = 10'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_MASK  = 2'd0,
        REG_ROOT_DEGREE = 2'd1,
        REG_HYSTERESIS  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [MASK_W-1:0] scale_mask;
        logic [ROOT_W-1:0] root_degree;
        logic [HYST_W-1:0] hysteresis_cents;
    } cfg_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] cents;
        logic signed [NOTE_W-1:0]  best;
        logic signed [CENTS_W-1:0] best_c;
        logic [DEG_W-1:0]          best_mod;
    } entry_t;

    // candidate index i stands for offset i - SPAN; orders list nearest first
    localparam logic [OFF_W-1:0] ORD_POS [CAND] = '{
        5'd12, 5'd13, 5'd11, 5'd14, 5'd10, 5'd15, 5'd9, 5'd16, 5'd8, 5'd17,
        5'd7, 5'd18, 5'd6, 5'd19, 5'd5, 5'd20, 5'd4, 5'd21, 5'd3, 5'd22,
        5'd2, 5'd23, 5'd1, 5'd24, 5'd0};
    localparam logic [OFF_W-1:0] ORD_NEG [CAND] = '{
        5'd12, 5'd11, 5'd13, 5'd10, 5'd14, 5'd9, 5'd15, 5'd8, 5'd16, 5'd7,
        5'd17, 5'd6, 5'd18, 5'd5, 5'd19, 5'd4, 5'd20, 5'd3, 5'd21, 5'd2,
        5'd22, 5'd1, 5'd23, 5'd0, 5'd24};
    localparam logic [OFF_W-1:0] ORD_HALF [CAND] = '{
        5'd11, 5'd12, 5'd10, 5'd13, 5'd9, 5'd14, 5'd8, 5'd15, 5'd7, 5'd16,
        5'd6, 5'd17, 5'd5, 5'd18, 5'd4, 5'd19, 5'd3, 5'd20, 5'd2, 5'd21,
        5'd1, 5'd22, 5'd0, 5'd23, 5'd24};

    localparam logic [DEG_W-1:0] OFF_MOD12 [CAND] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
        4'd0};

    localparam logic signed [NOTE_W-1:0] OFF_CENTS [CAND] = '{
        -12'sd1200, -12'sd1100, -12'sd1000, -12'sd900, -12'sd800, -12'sd700,
        -12'sd600, -12'sd500, -12'sd400, -12'sd300, -12'sd200, -12'sd100,
        12'sd0, 12'sd100, 12'sd200, 12'sd300, 12'sd400, 12'sd500, 12'sd600,
        12'sd700, 12'sd800, 12'sd900, 12'sd1000, 12'sd1100, 12'sd1200};

    function automatic logic [DEG_W-1:0] root_mod12(input logic [ROOT_W-1:0] root);
        logic [DEG_W-1:0] r;
        r = (root >= DEG_W'(OCTAVE)) ? root - DEG_W'(OCTAVE) : root;
        return r;
    endfunction

    // a, b in 0..11
    function automatic logic [DEG_W-1:0] add_mod12(input logic [DEG_W-1:0] a,
                                                   input logic [DEG_W-1:0] b);
        logic [DEG_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (DEG_W+1)'(OCTAVE))
        begin
            s = s - (DEG_W+1)'(OCTAVE);
        end
        return s[DEG_W-1:0];
    endfunction

    function automatic logic [DEG_W-1:0] sub_mod12(input logic [DEG_W-1:0] a,
                                                   input logic [DEG_W-1:0] b);
        logic [DEG_W:0] s;
        s = {1'b0, a} + (DEG_W+1)'(OCTAVE) - {1'b0, b};
        if (s >= (DEG_W+1)'(OCTAVE))
        begin
            s = s - (DEG_W+1)'(OCTAVE);
        end
        return s[DEG_W-1:0];
    endfunction

endpackage

### design/smpq_front.sv
// ----------------------------------------------------------------------------
// Quantizer front end
// Three-stage pipeline: rounding to the nearest semitone, remainder and
// octave degree, then the 25-way scale search. Pushes words into the queue.
// ----------------------------------------------------------------------------
module smpq_front #(
    parameter int DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smpq_pkg::cfg_t                     cfg,
    input  logic                               pitch_valid,
    output logic                               pitch_stall,
    input  logic signed [smpq_pkg::PITCH_W-1:0] pitch_cents,
    input  logic [CNT_W-1:0]                   fifo_count,
    output logic                               push,
    output smpq_pkg::entry_t                   push_data
);
    import smpq_pkg::*;

    logic [CNT_W:0]   occ;
    logic             accept;

    logic [BIASED_W-1:0]                 biased;
    logic [BIASED_W+RECIP_100_W-1:0]     prod1;
    logic                                v1_reg;
    logic signed [PITCH_W-1:0]           cents1_reg;
    logic [Q_W-1:0]                      q1_reg;
    logic [Q_W-1:0]                      q1_next;

    logic signed [NOTE_W-1:0]            nearest2_next;
    logic signed [CENTS_W-1:0]           nc2_next;
    logic signed [CENTS_W:0]             rem_w;
    logic [Q_W+RECIP_12_W-1:0]           qprod;
    logic [Q_W-1:0]                      qdiv;
    logic [DEG_W-1:0]                    qmod;
    logic                                v2_reg;
    logic signed [PITCH_W-1:0]           cents2_reg;
    logic signed [NOTE_W-1:0]            nearest2_reg;
    logic signed [CENTS_W-1:0]           nc2_reg;
    logic signed [REM_W-1:0]             r2_reg;
    logic [DEG_W-1:0]                    nmod2_reg;

    logic [DEG_W-1:0]                    base;
    logic [CAND-1:0]                     allowed;
    logic [OFF_W-1:0]                    ord [CAND];
    logic [OFF_W-1:0]                    sel;
    logic signed [OFF_W:0]               off;
    entry_t                              entry3_next;
    entry_t                              entry3_reg;
    logic                                v3_reg;

    assign occ = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(v1_reg) + (CNT_W+1)'(v2_reg)
               + (CNT_W+1)'(v3_reg);
    assign pitch_stall = (occ >= (CNT_W+1)'(DEPTH));
    assign accept      = pitch_valid && !pitch_stall;

    // stage 1
    always_comb
    begin
        biased  = {pitch_cents[PITCH_W-1], pitch_cents} + BIASED_W'(PITCH_BIAS);
        prod1   = (BIASED_W+RECIP_100_W)'(biased) * (BIASED_W+RECIP_100_W)'(RECIP_100);
        q1_next = Q_W'(prod1 >> RECIP_100_SH);
    end

    // stage 2
    always_comb
    begin
        nearest2_next = NOTE_W'($signed({1'b0, q1_reg}) - $signed((Q_W+1)'(NEAR_BIAS)));
        nc2_next      = CENTS_W'(CENTS_W'(nearest2_next) * $signed(CENTS_W'(CENTS_PER)));
        rem_w         = (CENTS_W+1)'(cents1_reg) - (CENTS_W+1)'(nc2_next);
        qprod         = (Q_W+RECIP_12_W)'(q1_reg) * (Q_W+RECIP_12_W)'(RECIP_12);
        qdiv          = Q_W'(qprod >> RECIP_12_SH);
        qmod          = DEG_W'(q1_reg - qdiv * Q_W'(OCTAVE));
    end

    // stage 3: scale search
    always_comb
    begin
        base = sub_mod12(nmod2_reg, root_mod12(cfg.root_degree));
        for (int i = 0; i < CAND; i++)
        begin
            allowed[i] = cfg.scale_mask[add_mod12(base, OFF_MOD12[i])];
        end
        for (int k = 0; k < CAND; k++)
        begin
            if (r2_reg > REM_W'(0))
            begin
                ord[k] = ORD_POS[k];
            end
            else if (r2_reg == $signed(REM_W'(HALF_NEG)))
            begin
                ord[k] = ORD_HALF[k];
            end
            else
            begin
                ord[k] = ORD_NEG[k];
            end
        end
        sel = OFF_W'(SPAN);
        for (int k = CAND - 1; k >= 0; k--)
        begin
            if (allowed[ord[k]])
            begin
                sel = ord[k];
            end
        end
        off                  = $signed({1'b0, sel}) - $signed((OFF_W+1)'(SPAN));
        entry3_next.cents    = cents2_reg;
        entry3_next.best     = nearest2_reg + NOTE_W'(off);
        entry3_next.best_c   = nc2_reg + CENTS_W'(OFF_CENTS[sel]);
        entry3_next.best_mod = add_mod12(nmod2_reg, OFF_MOD12[sel]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cents1_reg   <= pitch_cents;
        q1_reg       <= q1_next;
        cents2_reg   <= cents1_reg;
        nearest2_reg <= nearest2_next;
        nc2_reg      <= nc2_next;
        r2_reg       <= REM_W'(rem_w);
        nmod2_reg    <= sub_mod12(qmod, DEG_W'(NEAR_MOD_BIAS));
        entry3_reg   <= entry3_next;
    end

    assign push      = v3_reg;
    assign push_data = entry3_reg;

endmodule

### design/smpq_fifo.sv
// ----------------------------------------------------------------------------
// Quantizer word queue
// Short register queue between the search pipeline and the hysteresis stage.
// ----------------------------------------------------------------------------
module smpq_fifo #(
    parameter int DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  smpq_pkg::entry_t push_data,
    input  logic             pop,
    output smpq_pkg::entry_t pop_data,
    output logic [CNT_W-1:0] count
);
    import smpq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign count    = count_reg;

endmodule

### design/smpq_back.sv
// ----------------------------------------------------------------------------
// Quantizer back end
// Hysteresis against the held note, empty-mask handling and the output
// register. Takes one word from the queue per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "scale_mask_pitch_quantizer_macros.svh"

module smpq_back #(
    parameter int DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smpq_pkg::cfg_t                     cfg,
    input  logic [CNT_W-1:0]                   fifo_count,
    input  smpq_pkg::entry_t                   pop_data,
    output logic                               pop,
    output logic                               note_valid,
    input  logic                               note_stall,
    output logic signed [smpq_pkg::NOTE_W-1:0] note_number
);
    import smpq_pkg::*;

    localparam int DIST_W = CENTS_W + 2;

    logic                      held_valid_reg;
    logic                      held_valid_next;
    logic signed [NOTE_W-1:0]  held_reg;
    logic signed [NOTE_W-1:0]  held_next;
    logic signed [CENTS_W-1:0] held_c_reg;
    logic signed [CENTS_W-1:0] held_c_next;
    logic [DEG_W-1:0]          held_mod_reg;
    logic [DEG_W-1:0]          held_mod_next;
    logic                      note_valid_reg;
    logic                      note_valid_next;
    logic signed [NOTE_W-1:0]  note_number_reg;
    logic signed [NOTE_W-1:0]  note_number_next;

    logic                      held_ok;
    logic signed [DIST_W-1:0]  dh_s;
    logic signed [DIST_W-1:0]  gap_s;
    logic [DIST_W-1:0]         dh_abs;
    logic [DIST_W-1:0]         gap_abs;
    logic [DIST_W-1:0]         thr;
    logic                      keep;
    logic                      held_c_ok;

    assign pop = (fifo_count != '0) && (!note_valid_reg || !note_stall);

    always_comb
    begin
        held_ok = cfg.scale_mask[sub_mod12(held_mod_reg, root_mod12(cfg.root_degree))];
        dh_s    = DIST_W'(pop_data.cents) - DIST_W'(held_c_reg);
        gap_s   = DIST_W'(pop_data.best_c) - DIST_W'(held_c_reg);
        dh_abs  = (dh_s < 0) ? DIST_W'(-dh_s) : DIST_W'(dh_s);
        gap_abs = (gap_s < 0) ? DIST_W'(-gap_s) : DIST_W'(gap_s);
        thr     = (gap_abs >> 1) + DIST_W'(cfg.hysteresis_cents);
        keep    = held_valid_reg && (pop_data.best != held_reg) && held_ok && (dh_abs <= thr);

        held_valid_next  = held_valid_reg;
        held_next        = held_reg;
        held_c_next      = held_c_reg;
        held_mod_next    = held_mod_reg;
        note_number_next = note_number_reg;
        note_valid_next  = note_valid_reg && note_stall;

        if (pop)
        begin
            note_valid_next = 1'b1;
            held_valid_next = 1'b1;
            if (cfg.scale_mask == '0)
            begin
                if (!held_valid_reg)
                begin
                    held_next     = '0;
                    held_c_next   = '0;
                    held_mod_next = '0;
                end
                note_number_next = held_valid_reg ? held_reg : '0;
            end
            else if (keep)
            begin
                note_number_next = held_reg;
            end
            else
            begin
                held_next        = pop_data.best;
                held_c_next      = pop_data.best_c;
                held_mod_next    = pop_data.best_mod;
                note_number_next = pop_data.best;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            held_c_reg     <= '0;
            held_mod_reg   <= '0;
            note_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            held_c_reg     <= held_c_next;
            held_mod_reg   <= held_mod_next;
            note_valid_reg <= note_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_number_reg <= note_number_next;
    end

    assign note_valid  = note_valid_reg;
    assign note_number = note_number_reg;

    assign held_c_ok = (DIST_W'(held_reg) * $signed(DIST_W'(CENTS_PER))) == DIST_W'(held_c_reg);

    `SMPQ_ASSERT_NEXT(a_pop_sets_held, pop, held_valid_reg && note_valid_reg, "pop lost held state")
    `SMPQ_ASSERT_SAME(a_no_pop_on_stall, note_valid_reg && note_stall, !pop, "pop while stalled")
    `SMPQ_ASSERT_SAME(a_held_mod_range, held_valid_reg, held_mod_reg < DEG_W'(OCTAVE), "bad degree")
    `SMPQ_ASSERT_SAME(a_held_cents, held_valid_reg, held_c_ok, "held cents out of step")

endmodule

### design/scale_mask_pitch_quantizer.sv
// ----------------------------------------------------------------------------
// Scale-mask pitch quantizer
// Rounds a pitch in cents to the nearest note allowed by a 12-degree scale
// mask, with hysteresis against the previously held note; an empty mask repeats the held note, or 0.
//
//   channel   dir   handshake                 word
//   config    in    cfg_we                    cfg_index, cfg_data
//   pitch     in    pitch_valid/pitch_stall   pitch_cents
//   note      out   note_valid/note_stall     note_number
//
// One word per cycle sustained while note_stall is low; an accepted pitch passes the front stages and the queue.
// The held-note compare is combinational in the back stage, which sets
// the rate; the search runs in a three-stage front pipeline.
// Reset: asynchronous, config and control registers at their reset values, no note held.
// pitch_stall rises once queue plus front stages hold QUEUE_DEPTH words.
// ----------------------------------------------------------------------------
module scale_mask_pitch_quantizer #(
    parameter int QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [smpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smpq_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                pitch_valid,
    output logic                                pitch_stall,
    input  logic signed [smpq_pkg::PITCH_W-1:0] pitch_cents,
    output logic                                note_valid,
    input  logic                                note_stall,
    output logic signed [smpq_pkg::NOTE_W-1:0]  note_number
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [MASK_W-1:0] scale_mask_reg;
    logic [ROOT_W-1:0] root_degree_reg;
    logic [HYST_W-1:0] hysteresis_reg;
    cfg_t              cfg;

    logic              push;
    entry_t            push_data;
    logic              pop;
    entry_t            pop_data;
    logic [CNT_W-1:0]  fifo_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mask_reg  <= MASK_RESET;
            root_degree_reg <= ROOT_RESET;
            hysteresis_reg  <= HYST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCALE_MASK:  scale_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_ROOT_DEGREE: root_degree_reg <= cfg_data[ROOT_W-1:0];
                REG_HYSTERESIS:  hysteresis_reg  <= cfg_data[HYST_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.scale_mask       = scale_mask_reg;
    assign cfg.root_degree      = root_degree_reg;
    assign cfg.hysteresis_cents = hysteresis_reg;

    smpq_front #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pitch_valid (pitch_valid),
        .pitch_stall (pitch_stall),
        .pitch_cents (pitch_cents),
        .fifo_count  (fifo_count),
        .push        (push),
        .push_data   (push_data)
    );

    smpq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    smpq_back #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fifo_count  (fifo_count),
        .pop_data    (pop_data),
        .pop         (pop),
        .note_valid  (note_valid),
        .note_stall  (note_stall),
        .note_number (note_number)
    );

endmodule
